// ===== rtl/tht_pkg.sv =====
// shared types and constants for the terrain height sampler
package tht_pkg;

   // heightmap geometry
   localparam int MAP_SIZE_LOG2 = 8;
   localparam int MAP_SIZE      = 1 << MAP_SIZE_LOG2;
   localparam int ADDR_W        = 2 * MAP_SIZE_LOG2;
   localparam int STORE_DEPTH   = 1 << ADDR_W;

   // queue sizes
   localparam int CMDQ_DEPTH  = 4;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
   localparam int OUTQ_DEPTH  = 8;
   localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);
   localparam int BACK_STAGES = 5;
   localparam int INFL_W      = $clog2(BACK_STAGES + 1);

   // opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_HALF_EXTENT  = 2'd0;
   localparam logic [1:0] CSR_INV_EXTENT   = 2'd1;
   localparam logic [1:0] CSR_HEIGHT_SCALE = 2'd2;
   localparam logic [15:0] HEIGHT_SCALE_RESET = 16'd256;

   typedef logic [MAP_SIZE_LOG2-1:0] idx_type;
   typedef logic [ADDR_W-1:0]        addr_type;

   typedef struct packed {
      logic [30:0] half_extent;
      logic [31:0] inv_extent;
      logic [15:0] height_scale;
   } cfg_type;

   // one classified item between front and back
   typedef struct packed {
      logic        is_query;
      logic        wr_en;
      addr_type    wr_addr;
      logic [15:0] wr_data;
      idx_type     x0;
      idx_type     x1;
      idx_type     z0;
      idx_type     z1;
      logic [15:0] u;
      logic [15:0] v;
   } cmd_type;

   typedef struct packed {
      logic                  issue;
      logic [OUTQ_CNT_W-1:0] out_count;
      logic [INFL_W-1:0]     inflight;
   } back_status_type;

endpackage

// ===== rtl/terrain_height_triangle_interp.sv =====
// top level of the terrain height sampler: registers, front, back, checks
// A query goes through the front stages, the command queue and the back pipeline into
// the result queue; writes give no result and reach the store. Without stalls the block takes
// one item per cycle, set by the two-copy store giving four heights a cycle.
// Reset: clears queues and pipeline valids and the registers (height_scale to 256);
// heightmap contents stay undefined until written.
module terrain_height_triangle_interp (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_opcode,
   input  logic signed [31:0]  req_coord_x,
   input  logic signed [31:0]  req_coord_z,
   input  logic [15:0]         req_sample_addr,
   input  logic signed [15:0]  req_sample_value,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic signed [39:0]  rsp_height,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);
   import tht_pkg::*;

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   cmd_type         cmd_head;
   logic            cmd_valid;
   logic            cmd_pop;
   back_status_type back_status;

   // register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HALF_EXTENT:  cfg_in.half_extent  = csr_data[30:0];
            CSR_INV_EXTENT:   cfg_in.inv_extent   = csr_data;
            CSR_HEIGHT_SCALE: cfg_in.height_scale = csr_data[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_extent  <= '0;
         cfg_ff.inv_extent   <= '0;
         cfg_ff.height_scale <= HEIGHT_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tht_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_coord_x      (req_coord_x),
      .req_coord_z      (req_coord_z),
      .req_sample_addr  (req_sample_addr),
      .req_sample_value (req_sample_value),
      .cmd_pop          (cmd_pop),
      .cmd_head         (cmd_head),
      .cmd_valid        (cmd_valid)
   );

   tht_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd_head   (cmd_head),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_height (rsp_height),
      .status     (back_status)
   );

   // reset leaves both sides open and empty
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("queues not cleared by reset");

   // results in flight never exceed the result queue
   a_outq_bound: assert property (@(posedge clock) disable iff (reset)
      ((OUTQ_CNT_W+1)'(back_status.out_count) + (OUTQ_CNT_W+1)'(back_status.inflight))
         <= (OUTQ_CNT_W+1)'(OUTQ_DEPTH))
      else $error("result queue overcommitted");

   // back never takes from an empty command queue
   a_issue_valid: assert property (@(posedge clock) disable iff (reset)
      back_status.issue |-> cmd_valid)
      else $error("issue from empty command queue");

endmodule

// ===== rtl/tht_ram.sv =====
// generic single write, dual read memory with registered read data
module tht_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr_a,
   input  logic [AddrW-1:0] rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // write port and two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/tht_front.sv =====
// front part: takes items, maps coordinates to cell and weights, command queue
module tht_front (
   input  logic                 clock,
   input  logic                 reset,
   input  tht_pkg::cfg_type     cfg,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_opcode,
   input  logic signed [31:0]   req_coord_x,
   input  logic signed [31:0]   req_coord_z,
   input  logic [15:0]          req_sample_addr,
   input  logic signed [15:0]   req_sample_value,
   input  logic                 cmd_pop,
   output tht_pkg::cmd_type     cmd_head,
   output logic                 cmd_valid
);
   import tht_pkg::*;

   logic                  s1_vld_ff, s1_vld_in;
   logic                  s1_op_ff;
   logic [31:0]           s1_x_ff, s1_z_ff;
   logic [15:0]           s1_addr_ff, s1_value_ff;
   logic                  s2_vld_ff, s2_vld_in;
   logic                  s2_op_ff;
   logic [31:0]           s2_fx_ff, s2_fx_in;
   logic [31:0]           s2_fz_ff, s2_fz_in;
   logic [15:0]           s2_addr_ff, s2_value_ff;
   cmd_type               cq_mem_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] cq_wr_ff, cq_wr_in;
   logic [CMDQ_PTR_W-1:0] cq_rd_ff, cq_rd_in;
   logic [CMDQ_CNT_W-1:0] cq_count_ff, cq_count_in;
   logic                  accept, s1_move, s2_move, s1_free, s2_free, q_full;
   logic signed [32:0]    px, pz;
   logic signed [65:0]    prod_x, prod_z;
   cmd_type               entry;

   // stage flow control
   assign q_full   = (cq_count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign s2_move  = s2_vld_ff & ~q_full;
   assign s2_free  = ~s2_vld_ff | s2_move;
   assign s1_move  = s1_vld_ff & s2_free;
   assign s1_free  = ~s1_vld_ff | s1_move;
   assign req_full = ~s1_free;
   assign accept   = req_push & ~req_full;

   assign s1_vld_in = accept | (s1_vld_ff & ~s1_move);
   assign s2_vld_in = s1_move | (s2_vld_ff & ~s2_move);

   // wrap position: (coord + half extent) * inverse extent, keep bits 47..16
   assign px     = {s1_x_ff[31], s1_x_ff} + {2'b00, cfg.half_extent};
   assign pz     = {s1_z_ff[31], s1_z_ff} + {2'b00, cfg.half_extent};
   assign prod_x = px * $signed({1'b0, cfg.inv_extent});
   assign prod_z = pz * $signed({1'b0, cfg.inv_extent});
   assign s2_fx_in = prod_x[47:16];
   assign s2_fz_in = prod_z[47:16];

   // classify the item and split fractions into cell index and weight
   always_comb begin
      entry          = '0;
      entry.is_query = (s2_op_ff == OP_QUERY);
      entry.wr_en    = (32'(s2_addr_ff) < 32'(STORE_DEPTH));
      entry.wr_addr  = ADDR_W'(s2_addr_ff);
      entry.wr_data  = s2_value_ff;
      entry.x0       = s2_fx_ff[31 -: MAP_SIZE_LOG2];
      entry.z0       = s2_fz_ff[31 -: MAP_SIZE_LOG2];
      entry.u        = s2_fx_ff[31-MAP_SIZE_LOG2 -: 16];
      entry.v        = s2_fz_ff[31-MAP_SIZE_LOG2 -: 16];
      // neighbour index clamped at the map edge
      entry.x1 = (entry.x0 == idx_type'(MAP_SIZE - 1)) ? entry.x0 : entry.x0 + 1'b1;
      entry.z1 = (entry.z0 == idx_type'(MAP_SIZE - 1)) ? entry.z0 : entry.z0 + 1'b1;
   end

   // command queue pointers
   assign cq_wr_in    = s2_move ? cq_wr_ff + 1'b1 : cq_wr_ff;
   assign cq_rd_in    = cmd_pop ? cq_rd_ff + 1'b1 : cq_rd_ff;
   assign cq_count_in = cq_count_ff + CMDQ_CNT_W'(s2_move) - CMDQ_CNT_W'(cmd_pop);
   assign cmd_valid   = (cq_count_ff != '0);
   assign cmd_head    = cq_mem_ff[cq_rd_ff];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         cq_wr_ff    <= '0;
         cq_rd_ff    <= '0;
         cq_count_ff <= '0;
      end else begin
         s1_vld_ff   <= s1_vld_in;
         s2_vld_ff   <= s2_vld_in;
         cq_wr_ff    <= cq_wr_in;
         cq_rd_ff    <= cq_rd_in;
         cq_count_ff <= cq_count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_opcode;
         s1_x_ff     <= req_coord_x;
         s1_z_ff     <= req_coord_z;
         s1_addr_ff  <= req_sample_addr;
         s1_value_ff <= req_sample_value;
      end
      if (s1_move) begin
         s2_op_ff    <= s1_op_ff;
         s2_fx_ff    <= s2_fx_in;
         s2_fz_ff    <= s2_fz_in;
         s2_addr_ff  <= s1_addr_ff;
         s2_value_ff <= s1_value_ff;
      end
      if (s2_move) begin
         cq_mem_ff[cq_wr_ff] <= entry;
      end
   end

endmodule

// ===== rtl/tht_back.sv =====
// back part: heightmap store, triangle interpolation, scaling and result queue
module tht_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tht_pkg::cfg_type          cfg,
   input  tht_pkg::cmd_type          cmd_head,
   input  logic                      cmd_valid,
   output logic                      cmd_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic signed [39:0]        rsp_height,
   output tht_pkg::back_status_type  status
);
   import tht_pkg::*;

   logic                  issue, room, wr_en, out_pop;
   logic [INFL_W-1:0]     inflight;
   logic [15:0]           rd_a0, rd_a1, rd_b0, rd_b1;
   logic signed [15:0]    h0, h1, h2, h3;
   logic                  lower;
   logic                  b1_vld_ff, b2_vld_ff, b3_vld_ff, b4_vld_ff, b5_vld_ff;
   logic [15:0]           b1_u_ff, b1_v_ff, b2_u_ff, b2_v_ff;
   logic signed [15:0]    b2_h0_ff, b3_h0_ff;
   logic signed [16:0]    b2_du_ff, b2_du_in, b2_dv_ff, b2_dv_in;
   logic signed [33:0]    b3_pu_ff, b3_pu_in, b3_pv_ff, b3_pv_in;
   logic signed [34:0]    b4_acc_ff, b4_acc_in;
   logic signed [51:0]    b5_scaled_ff, b5_scaled_in;
   logic signed [39:0]    out_data;
   logic signed [39:0]    oq_mem_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] oq_wr_ff, oq_wr_in, oq_rd_ff, oq_rd_in;
   logic [OUTQ_CNT_W-1:0] oq_count_ff, oq_count_in;

   // issue a query only when the result queue is sure to have room for it
   assign inflight = INFL_W'(b1_vld_ff) + INFL_W'(b2_vld_ff) + INFL_W'(b3_vld_ff)
                   + INFL_W'(b4_vld_ff) + INFL_W'(b5_vld_ff);
   assign room  = ((OUTQ_CNT_W+1)'(oq_count_ff) + (OUTQ_CNT_W+1)'(inflight))
                  < (OUTQ_CNT_W+1)'(OUTQ_DEPTH);
   assign issue   = cmd_valid & (~cmd_head.is_query | room);
   assign cmd_pop = issue;
   assign wr_en   = issue & ~cmd_head.is_query & cmd_head.wr_en;

   // two copies of the store, each giving one row of the cell
   tht_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_ram_row0 (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (cmd_head.wr_addr),
      .wr_data   (cmd_head.wr_data),
      .rd_addr_a ({cmd_head.z0, cmd_head.x0}),
      .rd_addr_b ({cmd_head.z0, cmd_head.x1}),
      .rd_data_a (rd_a0),
      .rd_data_b (rd_a1)
   );

   tht_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_ram_row1 (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (cmd_head.wr_addr),
      .wr_data   (cmd_head.wr_data),
      .rd_addr_a ({cmd_head.z1, cmd_head.x0}),
      .rd_addr_b ({cmd_head.z1, cmd_head.x1}),
      .rd_data_a (rd_b0),
      .rd_data_b (rd_b1)
   );

   // triangle choice and edge differences
   assign h0    = rd_a0;
   assign h1    = rd_a1;
   assign h2    = rd_b0;
   assign h3    = rd_b1;
   assign lower = (b1_u_ff > b1_v_ff);
   assign b2_du_in = lower ? ({h1[15], h1} - {h0[15], h0}) : ({h3[15], h3} - {h2[15], h2});
   assign b2_dv_in = lower ? ({h3[15], h3} - {h1[15], h1}) : ({h2[15], h2} - {h0[15], h0});

   // weighted differences
   assign b3_pu_in = b2_du_ff * $signed({1'b0, b2_u_ff});
   assign b3_pv_in = b2_dv_ff * $signed({1'b0, b2_v_ff});

   // interpolated height in Q19.16
   assign b4_acc_in = $signed({{3{b3_h0_ff[15]}}, b3_h0_ff, 16'h0000})
                    + $signed({b3_pu_ff[33], b3_pu_ff})
                    + $signed({b3_pv_ff[33], b3_pv_ff});

   // vertical scale, then drop sixteen fraction bits with floor
   assign b5_scaled_in = b4_acc_ff * $signed({1'b0, cfg.height_scale});
   assign out_data     = {{4{b5_scaled_ff[51]}}, b5_scaled_ff[51:16]};

   // result queue
   assign out_pop     = rsp_pop & ~rsp_empty;
   assign oq_wr_in    = b5_vld_ff ? oq_wr_ff + 1'b1 : oq_wr_ff;
   assign oq_rd_in    = out_pop ? oq_rd_ff + 1'b1 : oq_rd_ff;
   assign oq_count_in = oq_count_ff + OUTQ_CNT_W'(b5_vld_ff) - OUTQ_CNT_W'(out_pop);
   assign rsp_empty   = (oq_count_ff == '0);
   assign rsp_height  = oq_mem_ff[oq_rd_ff];

   assign status.issue     = issue;
   assign status.out_count = oq_count_ff;
   assign status.inflight  = inflight;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff   <= 1'b0;
         b2_vld_ff   <= 1'b0;
         b3_vld_ff   <= 1'b0;
         b4_vld_ff   <= 1'b0;
         b5_vld_ff   <= 1'b0;
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_count_ff <= '0;
      end else begin
         b1_vld_ff   <= issue & cmd_head.is_query;
         b2_vld_ff   <= b1_vld_ff;
         b3_vld_ff   <= b2_vld_ff;
         b4_vld_ff   <= b3_vld_ff;
         b5_vld_ff   <= b4_vld_ff;
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
         oq_count_ff <= oq_count_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      b1_u_ff      <= cmd_head.u;
      b1_v_ff      <= cmd_head.v;
      b2_u_ff      <= b1_u_ff;
      b2_v_ff      <= b1_v_ff;
      b2_h0_ff     <= h0;
      b2_du_ff     <= b2_du_in;
      b2_dv_ff     <= b2_dv_in;
      b3_h0_ff     <= b2_h0_ff;
      b3_pu_ff     <= b3_pu_in;
      b3_pv_ff     <= b3_pv_in;
      b4_acc_ff    <= b4_acc_in;
      b5_scaled_ff <= b5_scaled_in;
      if (b5_vld_ff) begin
         oq_mem_ff[oq_wr_ff] <= out_data;
      end
   end

endmodule
